// File: rtl/dbba_pkg.sv
// Shared types and constants for the disk block bitmap allocator.
package dbba_pkg;

  localparam int CYLINDERS_DEF         = 8;
  localparam int BLOCKS_PER_CYL_DEF    = 8;
  localparam int RECORDS_PER_TRACK_DEF = 4;
  localparam int RESULT_LIMIT          = 64;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_BAD_ADDRESS  = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_RD,
    S_A_LOAD,
    S_A_SCAN,
    S_R_RD,
    S_R_CHK
  } state_t;

  typedef struct packed {
    logic       vld;
    status_t    status;
    logic       addr_vld;
    logic [2:0] cyl;
    logic       trk;
    logic [1:0] rec;
    logic       last;
  } result_t;

endpackage

// File: rtl/dbba_ram.sv
// Generic simple dual-port RAM with registered read data.
module dbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/disk_block_bitmap_allocator.sv
// Top level of the disk block bitmap allocator: control, scan and map RAM.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// in_op selects allocate (in_block_count blocks) or release (the block named
// by in_cylinder_in / in_track_in / in_record_in). Results leave on the out_
// ports for exactly one cycle each, marked by out_valid; out_last flags the
// final result of a request. The receiver cannot stall, so nothing waits here.
//
// Timing: rejected requests (zero count, no space, bad address) answer from
// the idle state and leave busy low. A release answers after a map read
// and a check with write back. An allocate walks the map row by row
// through the single RAM read port: each row is read and loaded (rows that
// are full are skipped there), then its bit positions are scanned until the
// request is filled, one address per free bit. Busy stays high while rows
// are read and scanned and drops with the last address.
//
// Reset: the free counter loads the total block count and the per-row valid
// bits clear, so every row reads as free at once; there is no clearing pass.
module disk_block_bitmap_allocator
  import dbba_pkg::*;
#(
  parameter int CYLINDERS           = CYLINDERS_DEF,
  parameter int BLOCKS_PER_CYLINDER = BLOCKS_PER_CYL_DEF,
  parameter int RECORDS_PER_TRACK   = RECORDS_PER_TRACK_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_op,
  input  logic [6:0] in_block_count,
  input  logic [2:0] in_cylinder_in,
  input  logic       in_track_in,
  input  logic [1:0] in_record_in,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic       out_address_valid,
  output logic [2:0] out_cylinder_out,
  output logic       out_track_out,
  output logic [1:0] out_record_out,
  output logic [6:0] out_free_blocks,
  output logic       out_last
);

  localparam int AW    = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
  localparam int PW    = $clog2(BLOCKS_PER_CYLINDER);
  localparam int RW    = (RECORDS_PER_TRACK > 1) ? $clog2(RECORDS_PER_TRACK) : 1;
  localparam int TOTAL = CYLINDERS * BLOCKS_PER_CYLINDER;
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int BPC   = BLOCKS_PER_CYLINDER;

  // Control and scan state
  state_t          state_r, state_nxt;
  logic [6:0]      want_r, want_nxt;
  logic [AW-1:0]   cyl_r, cyl_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [RW-1:0]   rec_r, rec_nxt;
  logic            trk_r, trk_nxt;
  logic [BPC-1:0]  row_r, row_nxt;
  logic [CW-1:0]   free_r, free_nxt;
  logic [CYLINDERS-1:0] row_vld_r, row_vld_nxt;
  logic            rd_vld_r;

  // Captured release address
  logic [2:0]      rel_cyl_r, rel_cyl_nxt;
  logic            rel_trk_r, rel_trk_nxt;
  logic [1:0]      rel_rec_r, rel_rec_nxt;
  logic [PW-1:0]   rel_pos_r, rel_pos_nxt;

  // Result register
  result_t         res_r, res_nxt;
  logic [6:0]      out_free_r, out_free_nxt;

  // Map RAM port
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [BPC-1:0]  ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [BPC-1:0]  ram_rdata;

  logic            accept;
  logic [7:0]      rel_pos_wide;
  logic            rel_bad;
  logic            alloc_zero;
  logic            alloc_short;
  logic [BPC-1:0]  row_mask;
  logic [BPC-1:0]  scan_bit;
  logic [BPC-1:0]  rel_bit;
  logic            scan_free;
  logic            scan_done;
  logic            scan_eor;
  logic [BPC-1:0]  row_set;

  dbba_ram #(
    .WIDTH (BPC),
    .DEPTH (CYLINDERS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Bounds check on the release address, before any map access
  assign rel_pos_wide = in_track_in ? (8'(RECORDS_PER_TRACK) + {6'b0, in_record_in})
                                    : {6'b0, in_record_in};
  assign rel_bad = (32'(in_cylinder_in) >= 32'(CYLINDERS)) ||
                   (32'(in_record_in) >= 32'(RECORDS_PER_TRACK)) ||
                   (32'(rel_pos_wide) >= 32'(BPC));

  assign alloc_zero  = (in_block_count == 7'd0);
  assign alloc_short = (32'(in_block_count) > 32'(RESULT_LIMIT)) ||
                       (32'(in_block_count) > 32'(free_r));

  // A row never written since reset reads as all free
  assign row_mask  = rd_vld_r ? ram_rdata : '0;
  assign scan_bit  = {{(BPC-1){1'b0}}, 1'b1} << pos_r;
  assign rel_bit   = {{(BPC-1){1'b0}}, 1'b1} << rel_pos_r;
  assign scan_free = !row_r[pos_r];
  assign scan_done = scan_free && (want_r == 7'd1);
  assign scan_eor  = (pos_r == PW'(BPC - 1));
  assign row_set   = row_r | (scan_free ? scan_bit : '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_ALLOC) begin
            if (!alloc_zero && !alloc_short) begin
              state_nxt = S_A_RD;
            end
          end else if (!rel_bad) begin
            state_nxt = S_R_RD;
          end
        end
      end
      S_A_RD:   state_nxt = S_A_LOAD;
      S_A_LOAD: state_nxt = (&row_mask) ? S_A_RD : S_A_SCAN;
      S_A_SCAN: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end else if (scan_eor) begin
          state_nxt = S_A_RD;
        end
      end
      S_R_RD:   state_nxt = S_R_CHK;
      S_R_CHK:  state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM controls and results
  always_comb begin
    want_nxt    = want_r;
    cyl_nxt     = cyl_r;
    pos_nxt     = pos_r;
    rec_nxt     = rec_r;
    trk_nxt     = trk_r;
    row_nxt     = row_r;
    free_nxt    = free_r;
    row_vld_nxt = row_vld_r;
    rel_cyl_nxt = rel_cyl_r;
    rel_trk_nxt = rel_trk_r;
    rel_rec_nxt = rel_rec_r;
    rel_pos_nxt = rel_pos_r;
    res_nxt     = '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          want_nxt    = in_block_count;
          cyl_nxt     = '0;
          rel_cyl_nxt = in_cylinder_in;
          rel_trk_nxt = in_track_in;
          rel_rec_nxt = in_record_in;
          rel_pos_nxt = PW'(rel_pos_wide);
          if (in_op == OP_ALLOC) begin
            if (alloc_zero) begin
              res_nxt.vld    = 1'b1;
              res_nxt.status = ST_OK;
              res_nxt.last   = 1'b1;
            end else if (alloc_short) begin
              res_nxt.vld    = 1'b1;
              res_nxt.status = ST_NO_SPACE;
              res_nxt.last   = 1'b1;
            end
          end else if (rel_bad) begin
            res_nxt.vld    = 1'b1;
            res_nxt.status = ST_BAD_ADDRESS;
            res_nxt.last   = 1'b1;
          end
        end
      end
      S_A_RD: begin
        ram_raddr = cyl_r;
      end
      S_A_LOAD: begin
        // Skip full rows without scanning them
        row_nxt = row_mask;
        pos_nxt = '0;
        rec_nxt = '0;
        trk_nxt = 1'b0;
        if (&row_mask) begin
          cyl_nxt = cyl_r + 1'b1;
        end
      end
      S_A_SCAN: begin
        row_nxt = row_set;
        if (scan_free) begin
          res_nxt.vld      = 1'b1;
          res_nxt.status   = ST_OK;
          res_nxt.addr_vld = 1'b1;
          res_nxt.cyl      = 3'(cyl_r);
          res_nxt.trk      = trk_r;
          res_nxt.rec      = 2'(rec_r);
          res_nxt.last     = scan_done;
          free_nxt         = free_r - 1'b1;
          want_nxt         = want_r - 7'd1;
        end
        if (scan_done || scan_eor) begin
          // Write the row back once, when leaving it
          ram_we             = 1'b1;
          ram_waddr          = cyl_r;
          ram_wdata          = row_set;
          row_vld_nxt[cyl_r] = 1'b1;
          cyl_nxt            = cyl_r + 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
          if (rec_r == RW'(RECORDS_PER_TRACK - 1)) begin
            rec_nxt = '0;
            trk_nxt = ~trk_r;
          end else begin
            rec_nxt = rec_r + 1'b1;
          end
        end
      end
      S_R_RD: begin
        ram_raddr = AW'(rel_cyl_r);
      end
      S_R_CHK: begin
        res_nxt.vld  = 1'b1;
        res_nxt.last = 1'b1;
        if (row_mask[rel_pos_r]) begin
          ram_we                       = 1'b1;
          ram_waddr                    = AW'(rel_cyl_r);
          ram_wdata                    = row_mask & ~rel_bit;
          row_vld_nxt[AW'(rel_cyl_r)]  = 1'b1;
          free_nxt                     = free_r + 1'b1;
          res_nxt.status               = ST_OK;
          res_nxt.addr_vld             = 1'b1;
          res_nxt.cyl                  = rel_cyl_r;
          res_nxt.trk                  = rel_trk_r;
          res_nxt.rec                  = rel_rec_r;
        end else begin
          res_nxt.status = ST_ALREADY_FREE;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
    out_free_nxt = 7'(free_nxt);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      free_r    <= CW'(TOTAL);
      row_vld_r <= '0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      row_vld_r <= row_vld_nxt;
      res_r     <= res_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    want_r     <= want_nxt;
    cyl_r      <= cyl_nxt;
    pos_r      <= pos_nxt;
    rec_r      <= rec_nxt;
    trk_r      <= trk_nxt;
    row_r      <= row_nxt;
    rel_cyl_r  <= rel_cyl_nxt;
    rel_trk_r  <= rel_trk_nxt;
    rel_rec_r  <= rel_rec_nxt;
    rel_pos_r  <= rel_pos_nxt;
    out_free_r <= out_free_nxt;
    rd_vld_r   <= row_vld_r[ram_raddr];
  end

  assign out_valid         = res_r.vld;
  assign out_status        = res_r.status;
  assign out_address_valid = res_r.addr_vld;
  assign out_cylinder_out  = res_r.cyl;
  assign out_track_out     = res_r.trk;
  assign out_record_out    = res_r.rec;
  assign out_free_blocks   = out_free_r;
  assign out_last          = res_r.last;

  // Map writes only happen when a scanned row is left or a release commits
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_A_SCAN || state_r == S_R_CHK))
    else $error("map write outside scan or release check");

  // Every error result is a single, address-free result
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_last && !out_address_valid))
    else $error("error result not single or carries an address");

  // The final result of a request coincides with the control being idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (state_r == S_IDLE))
    else $error("last result while request still in progress");

  // The scan never runs with nothing left to allocate
  a_scan_want: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_SCAN) |-> (want_r != 7'd0))
    else $error("scan active with no blocks wanted");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CW'(TOTAL))
    else $error("free count above total blocks");

endmodule
